@@ design/rtpp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpp_pkg
// shared types, codes and tables of the ringtone text parser
// ----------------------------------------------------------------------------
package rtpp_pkg;

    // result kinds
    localparam logic [1:0] KIND_NOTE  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_DEF_DURATION = 2'd0;
    localparam logic [1:0] CFG_DEF_OCTAVE   = 2'd1;
    localparam logic [1:0] CFG_TEMPO        = 2'd2;

    // reset values of the configuration registers
    localparam logic [7:0]  RST_DEF_DURATION = 8'd4;
    localparam logic [7:0]  RST_DEF_OCTAVE   = 8'd6;
    localparam logic [15:0] RST_TEMPO        = 16'd63;

    // divider geometry: four beats of one minute in ms over the tempo
    localparam int          DIV_W     = 18;
    localparam logic [17:0] WHOLE_MS  = 18'd240000;
    localparam logic [3:0]  SEMI_REST = 4'd15;

    typedef struct packed {
        logic [7:0] tune_char;
        logic       end_of_tune;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [11:0] freq_hz;
        logic [15:0] dur_ms;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic       load;
        logic       pass;
        logic       div_start;
        logic       div_second;
        logic       finish;
        logic       end_push;
        logic       rd_idx;
    } rtpp_cmd_t;

    typedef struct packed {
        logic       again;
        logic       fin_req;
        logic       div_done;
        logic       end_flag;
        logic [1:0] count;
    } rtpp_sts_t;

    typedef struct packed {
        logic        wr;
        logic [1:0]  index;
        logic [15:0] data;
    } rtpp_cfg_t;

    // semitone of letters a..g
    function automatic logic [3:0] letter_semi(input logic [2:0] idx);
        logic [3:0] s;
        unique case (idx)
            3'd0:    s = 4'd9;
            3'd1:    s = 4'd11;
            3'd2:    s = 4'd0;
            3'd3:    s = 4'd2;
            3'd4:    s = 4'd4;
            3'd5:    s = 4'd5;
            3'd6:    s = 4'd7;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

    // octave four frequencies
    function automatic logic [11:0] base_freq(input logic [3:0] semi);
        logic [11:0] f;
        unique case (semi)
            4'd0:    f = 12'd262;
            4'd1:    f = 12'd277;
            4'd2:    f = 12'd294;
            4'd3:    f = 12'd311;
            4'd4:    f = 12'd330;
            4'd5:    f = 12'd349;
            4'd6:    f = 12'd370;
            4'd7:    f = 12'd392;
            4'd8:    f = 12'd415;
            4'd9:    f = 12'd440;
            4'd10:   f = 12'd466;
            4'd11:   f = 12'd494;
            default: f = 12'd0;
        endcase
        return f;
    endfunction

endpackage

@@ design/rtpp_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpp_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rtpp_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rtpp_pkg::DIV_W-1:0] dividend,
    input  logic [15:0]                divisor,
    output logic [rtpp_pkg::DIV_W-1:0] quotient,
    output logic                       done
);
    import rtpp_pkg::*;

    localparam logic [4:0] LAST_STEP = 5'(DIV_W - 1);

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [15:0]      rem_reg, rem_next;
    logic [15:0]      dvs_reg;
    logic [4:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [16:0]      trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_W-2:0], fits};
            rem_next = fits ? 16'(trial - {1'b0, dvs_reg}) : trial[15:0];
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

@@ design/rtpp_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpp_datapath
// parse state, one parse pass per command, note finish and result buffer
// ----------------------------------------------------------------------------
module rtpp_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rtpp_pkg::in_item_t    in_data,
    input  rtpp_pkg::rtpp_cfg_t   cfg,
    input  rtpp_pkg::rtpp_cmd_t   cmd,
    output rtpp_pkg::rtpp_sts_t   sts,
    output rtpp_pkg::out_item_t   out_data
);
    import rtpp_pkg::*;

    typedef enum logic [3:0] {
        PH_NAME, PH_HKEY, PH_HSKIP, PH_HNUM, PH_SEP,
        PH_DUR, PH_LETTER, PH_SHARP, PH_OCT, PH_HALT
    } phase_t;

    typedef enum logic [1:0] {KEY_NONE, KEY_D, KEY_O, KEY_B} key_t;

    phase_t      phase_reg, phase_next;
    key_t        key_reg, key_next;
    logic [15:0] accum_reg, accum_next;
    logic [7:0]  dd_reg, dd_next;
    logic [7:0]  doct_reg, doct_next;
    logic [15:0] tempo_reg, tempo_next;
    logic [15:0] ndur_reg, ndur_next;
    logic [3:0]  semi_reg, semi_next;
    logic        dot_reg, dot_next;
    logic        fagain_reg, fagain_next;
    logic [7:0]  char_reg;
    logic        end_reg;
    logic [7:0]  cfg_dd_reg, cfg_do_reg;
    logic [15:0] cfg_tempo_reg;
    logic [1:0]  cnt_reg, cnt_next;
    out_item_t   res_reg [2];

    logic        push_en;
    logic [1:0]  push_kind;
    logic [11:0] push_freq;
    logic [15:0] push_dur;
    logic        again, fin_req;

    logic        dig;
    logic [15:0] digit_val, acc10;
    logic [7:0]  lower;
    logic [15:0] oct;
    logic        div_zero;
    logic [DIV_W-1:0] quo;
    logic        div_done;
    logic [DIV_W:0]   ms_sum;
    logic [DIV_W-1:0] dividend;
    logic [15:0] divisor;

    assign dig       = !end_reg && char_reg >= 8'h30 && char_reg <= 8'h39;
    assign digit_val = {8'd0, 8'(char_reg - 8'h30)};
    assign acc10     = {accum_reg[12:0], 3'b000} + {accum_reg[14:0], 1'b0} + digit_val;
    assign lower     = (char_reg >= 8'h41 && char_reg <= 8'h5A) ? 8'(char_reg + 8'd32)
                                                                : char_reg;
    assign oct       = (accum_reg != 16'd0) ? accum_reg : {8'd0, doct_reg};
    assign div_zero  = tempo_reg == 16'd0 || ndur_reg == 16'd0;
    assign ms_sum    = {1'b0, quo} + (dot_reg ? {2'b00, quo[DIV_W-1:1]} : '0);
    assign dividend  = cmd.div_second ? quo : WHOLE_MS;
    assign divisor   = cmd.div_second ? ndur_reg : tempo_reg;

    rtpp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .quotient (quo),
        .done     (div_done)
    );

    always_comb
    begin
        phase_next  = phase_reg;
        key_next    = key_reg;
        accum_next  = accum_reg;
        dd_next     = dd_reg;
        doct_next   = doct_reg;
        tempo_next  = tempo_reg;
        ndur_next   = ndur_reg;
        semi_next   = semi_reg;
        dot_next    = dot_reg;
        fagain_next = fagain_reg;
        push_en     = 1'b0;
        push_kind   = KIND_ERROR;
        push_freq   = '0;
        push_dur    = '0;
        again       = 1'b0;
        fin_req     = 1'b0;

        if (cmd.pass)
        begin
            unique case (phase_reg)
                PH_NAME:
                begin
                    if (end_reg)
                    begin
                        push_en    = 1'b1;
                        phase_next = PH_HALT;
                    end
                    else if (char_reg == ":")
                    begin
                        dd_next    = cfg_dd_reg;
                        doct_next  = cfg_do_reg;
                        tempo_next = cfg_tempo_reg;
                        phase_next = PH_HKEY;
                    end
                end
                PH_HKEY:
                begin
                    if (end_reg)
                    begin
                        push_en    = 1'b1;
                        phase_next = PH_HALT;
                    end
                    else if (char_reg == ":")
                    begin
                        if (dd_reg == 8'd0 || tempo_reg == 16'd0)
                        begin
                            push_en    = 1'b1;
                            phase_next = PH_HALT;
                        end
                        else
                        begin
                            accum_next = '0;
                            phase_next = PH_SEP;
                        end
                    end
                    else if (char_reg == "d")
                    begin
                        key_next   = KEY_D;
                        phase_next = PH_HSKIP;
                    end
                    else if (char_reg == "o")
                    begin
                        key_next   = KEY_O;
                        phase_next = PH_HSKIP;
                    end
                    else if (char_reg == "b")
                    begin
                        key_next   = KEY_B;
                        phase_next = PH_HSKIP;
                    end
                end
                PH_HSKIP:
                begin
                    if (end_reg)
                    begin
                        push_en    = 1'b1;
                        phase_next = PH_HALT;
                    end
                    else
                    begin
                        accum_next = '0;
                        phase_next = PH_HNUM;
                    end
                end
                PH_HNUM:
                begin
                    if (dig)
                    begin
                        accum_next = acc10;
                    end
                    else
                    begin
                        unique case (key_reg)
                            KEY_D:    dd_next    = accum_reg[7:0];
                            KEY_O:    doct_next  = accum_reg[7:0];
                            KEY_B:    tempo_next = accum_reg;
                            default:  ;
                        endcase
                        key_next   = KEY_NONE;
                        accum_next = '0;
                        phase_next = PH_HKEY;
                        again      = 1'b1;
                    end
                end
                PH_SEP, PH_DUR:
                begin
                    if (phase_reg == PH_SEP && (end_reg || char_reg == "," || char_reg == " "))
                    begin
                    end
                    else if (dig)
                    begin
                        accum_next = (phase_reg == PH_SEP) ? digit_val : acc10;
                        phase_next = PH_DUR;
                    end
                    else
                    begin
                        if (phase_reg == PH_SEP)
                        begin
                            ndur_next = {8'd0, dd_reg};
                        end
                        else
                        begin
                            ndur_next  = (accum_reg != 16'd0) ? accum_reg : {8'd0, dd_reg};
                            accum_next = '0;
                        end
                        // note letter starts here
                        if (!end_reg)
                        begin
                            dot_next = 1'b0;
                        end
                        if (end_reg)
                        begin
                            push_en    = 1'b1;
                            phase_next = PH_HALT;
                        end
                        else if (lower >= "a" && lower <= "g")
                        begin
                            semi_next  = letter_semi(3'(lower - 8'h61));
                            phase_next = PH_LETTER;
                        end
                        else if (lower == "p")
                        begin
                            semi_next  = SEMI_REST;
                            phase_next = PH_LETTER;
                        end
                        else
                        begin
                            push_en    = 1'b1;
                            phase_next = PH_HALT;
                        end
                    end
                end
                PH_LETTER:
                begin
                    phase_next = PH_SHARP;
                    if (!end_reg && char_reg == "#")
                    begin
                        if (semi_reg < 4'd11)
                        begin
                            semi_next = semi_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        again = 1'b1;
                    end
                end
                PH_SHARP:
                begin
                    accum_next = '0;
                    if (!end_reg && char_reg == ".")
                    begin
                        dot_next   = 1'b1;
                        phase_next = PH_OCT;
                    end
                    else if (dig)
                    begin
                        accum_next = digit_val;
                        phase_next = PH_OCT;
                    end
                    else
                    begin
                        fin_req     = 1'b1;
                        fagain_next = 1'b1;
                    end
                end
                PH_OCT:
                begin
                    if (dig)
                    begin
                        accum_next = acc10;
                    end
                    else if (!end_reg && char_reg == ".")
                    begin
                        dot_next    = 1'b1;
                        fin_req     = 1'b1;
                        fagain_next = 1'b0;
                    end
                    else
                    begin
                        fin_req     = 1'b1;
                        fagain_next = 1'b1;
                    end
                end
                PH_HALT:
                begin
                end
                default:
                begin
                    phase_next = PH_HALT;
                end
            endcase
        end
        else if (cmd.finish)
        begin
            push_en = 1'b1;
            if (semi_reg != SEMI_REST
                && (oct < 16'd4 || oct > 16'd7 || semi_reg > 4'd11))
            begin
                phase_next = PH_HALT;
            end
            else
            begin
                push_kind  = KIND_NOTE;
                push_freq  = (semi_reg == SEMI_REST) ? 12'd0
                                                     : base_freq(semi_reg) << oct[1:0];
                push_dur   = div_zero ? 16'd0 : ms_sum[15:0];
                accum_next = '0;
                phase_next = PH_SEP;
                again      = fagain_reg;
            end
        end
        else if (cmd.end_push)
        begin
            push_en    = 1'b1;
            push_kind  = KIND_END;
            phase_next = PH_NAME;
            key_next   = KEY_NONE;
            accum_next = '0;
            ndur_next  = '0;
            semi_next  = SEMI_REST;
            dot_next   = 1'b0;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            cnt_next = '0;
        end
        else if (push_en)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_NAME;
            key_reg       <= KEY_NONE;
            accum_reg     <= '0;
            dd_reg        <= RST_DEF_DURATION;
            doct_reg      <= RST_DEF_OCTAVE;
            tempo_reg     <= RST_TEMPO;
            ndur_reg      <= '0;
            semi_reg      <= SEMI_REST;
            dot_reg       <= 1'b0;
            fagain_reg    <= 1'b0;
            cnt_reg       <= '0;
            cfg_dd_reg    <= RST_DEF_DURATION;
            cfg_do_reg    <= RST_DEF_OCTAVE;
            cfg_tempo_reg <= RST_TEMPO;
        end
        else
        begin
            phase_reg  <= phase_next;
            key_reg    <= key_next;
            accum_reg  <= accum_next;
            dd_reg     <= dd_next;
            doct_reg   <= doct_next;
            tempo_reg  <= tempo_next;
            ndur_reg   <= ndur_next;
            semi_reg   <= semi_next;
            dot_reg    <= dot_next;
            fagain_reg <= fagain_next;
            cnt_reg    <= cnt_next;
            if (cfg.wr)
            begin
                unique case (cfg.index)
                    CFG_DEF_DURATION: cfg_dd_reg    <= cfg.data[7:0];
                    CFG_DEF_OCTAVE:   cfg_do_reg    <= cfg.data[7:0];
                    CFG_TEMPO:        cfg_tempo_reg <= cfg.data;
                    default:          ;
                endcase
            end
        end
    end

    // item and result buffer, payload only
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            char_reg <= in_data.tune_char;
            end_reg  <= in_data.end_of_tune;
        end
        if (push_en && !cmd.load)
        begin
            res_reg[cnt_reg[0]] <= '{push_kind, push_freq, push_dur, 1'b0};
        end
    end

    assign sts.again    = again;
    assign sts.fin_req  = fin_req;
    assign sts.div_done = div_done;
    assign sts.end_flag = end_reg;
    assign sts.count    = cnt_reg;

    always_comb
    begin
        out_data      = res_reg[cmd.rd_idx];
        out_data.last = ({1'b0, cmd.rd_idx} == 2'(cnt_reg - 2'd1));
    end

endmodule

@@ design/rtpp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpp_ctrl
// sequencer: accept, parse passes, two divides per note, result delivery
// ----------------------------------------------------------------------------
module rtpp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  rtpp_pkg::rtpp_sts_t sts,
    output rtpp_pkg::rtpp_cmd_t cmd
);
    import rtpp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PASS, ST_DIV_A, ST_DIV_B, ST_FIN, ST_ENDP, ST_CHECK, ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   idx_reg, idx_next;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmd            = '0;
        cmd.rd_idx     = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PASS;
                end
            end
            ST_PASS:
            begin
                cmd.pass = 1'b1;
                if (sts.fin_req)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_A;
                end
                else if (!sts.again)
                begin
                    state_next = sts.end_flag ? ST_ENDP : ST_CHECK;
                end
            end
            ST_DIV_A:
            begin
                if (sts.div_done)
                begin
                    cmd.div_start  = 1'b1;
                    cmd.div_second = 1'b1;
                    state_next     = ST_DIV_B;
                end
            end
            ST_DIV_B:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                if (sts.again)
                begin
                    state_next = ST_PASS;
                end
                else
                begin
                    state_next = sts.end_flag ? ST_ENDP : ST_CHECK;
                end
            end
            ST_ENDP:
            begin
                cmd.end_push = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK:
            begin
                idx_next   = 1'b0;
                state_next = (sts.count == 2'd0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    if ({1'b0, idx_reg} == 2'(sts.count - 2'd1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = state_reg == ST_EMIT;

endmodule

@@ design/ringtone_text_note_parser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ringtone_text_note_parser_top
// ringtone text parser: characters in, notes with frequency and duration out
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  in        input      in_valid / in_stall   in_data  (tune_char, end_of_tune)
//  out       output     out_valid / out_stall out_data (kind, freq, dur, last)
//  cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
//  a character takes an accept, its parse passes, an end push at end of text,
//  a check and the delivery of each result
//  (at most two)
//  a finished note adds two 18-step passes of the shared
//  restoring divider (240000 / tempo, then / duration), each handed over
//  by the sequencer, and a finish step
//  reset leaves the parser in the name section with the built-in defaults
//  a stalled result holds; no new character is taken until all results of
//  the current one are delivered
// ----------------------------------------------------------------------------
module ringtone_text_note_parser_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rtpp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output rtpp_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import rtpp_pkg::*;

    rtpp_cmd_t cmd;
    rtpp_sts_t sts;
    rtpp_cfg_t cfg;

    // configuration is always taken
    assign cfg_ready = 1'b1;
    assign cfg.wr    = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // sequencer
    rtpp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // parse state, divider and result buffer
    rtpp_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cfg      (cfg),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data)
    );

    // no character taken while a result is offered
    a_no_accept_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !out_valid)
        else $error("character accepted while result pending");

    // an accepted character is parsed before any result appears
    a_parse_before_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !out_valid)
        else $error("result offered right after accept");

    // the last result of a character ends delivery
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_data.last) |=> (!out_valid && !in_stall))
        else $error("delivery continued after last transaction");

    // only defined kinds leave the block
    a_kind_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.result_kind == KIND_NOTE
                       || out_data.result_kind == KIND_END
                       || out_data.result_kind == KIND_ERROR))
        else $error("undefined result kind");

endmodule

@@ tb/ringtone_text_note_parser_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ringtone_text_note_parser_top_test
// drives ringtone text characters into the parser and checks every note, end
// and error transaction against a cycle-free predictor of the parse rules;
// covers header defaults, register settings, note syntax corners and random
// well-formed and broken tunes under random idling on both channels
// ----------------------------------------------------------------------------
module ringtone_text_note_parser_top_test;
    import rtpp_pkg::*;

    // parse phases of the predictor
    typedef enum logic [3:0] {
        PH_NAME, PH_HKEY, PH_HSKIP, PH_HNUM, PH_SEP,
        PH_DUR, PH_LETTER, PH_SHARP, PH_OCT, PH_HALT
    } phase_t;

    typedef enum logic [1:0] {KEY_NONE, KEY_D, KEY_O, KEY_B} hkey_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    int errors = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    out_item_t expected_notes[$];

    // predictor copy of registers and parser state
    logic [7:0]  reg_def_dur = RST_DEF_DURATION;
    logic [7:0]  reg_def_oct = RST_DEF_OCTAVE;
    logic [15:0] reg_tempo = RST_TEMPO;
    phase_t      phase = PH_NAME;
    hkey_t       hkey = KEY_NONE;
    logic [15:0] accum = '0;
    logic [7:0]  def_dur = RST_DEF_DURATION;
    logic [7:0]  def_oct = RST_DEF_OCTAVE;
    logic [15:0] tempo = RST_TEMPO;
    logic [15:0] note_dur = '0;
    logic [3:0]  note_semi = SEMI_REST;
    logic        dotted = 1'b0;
    logic        halted = 1'b0;
    int          produced;

    always #2 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2500000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    ringtone_text_note_parser_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ---------------------------------------------------------------- predictor
    function automatic logic [11:0] tone_freq(input logic [3:0] semi);
        case (semi)
            4'd0:  return 12'd262;
            4'd1:  return 12'd277;
            4'd2:  return 12'd294;
            4'd3:  return 12'd311;
            4'd4:  return 12'd330;
            4'd5:  return 12'd349;
            4'd6:  return 12'd370;
            4'd7:  return 12'd392;
            4'd8:  return 12'd415;
            4'd9:  return 12'd440;
            4'd10: return 12'd466;
            4'd11: return 12'd494;
            default: return 12'd0;
        endcase
    endfunction

    task automatic push_result(input logic [1:0] kind, input logic [11:0] f,
                               input logic [15:0] d);
        out_item_t r;
        r.result_kind = kind;
        r.freq_hz = f;
        r.dur_ms = d;
        r.last = 1'b0;
        expected_notes.push_back(r);
        produced++;
    endtask

    task automatic parse_fail();
        push_result(KIND_ERROR, '0, '0);
        halted = 1'b1;
        phase = PH_HALT;
    endtask

    task automatic accum_digit(input logic [7:0] c);
        accum = accum * 16'd10 + 16'(c - 8'd48);
    endtask

    task automatic begin_letter(input logic [7:0] c);
        logic [7:0] lc;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        dotted = 1'b0;
        if (lc >= "a" && lc <= "g")
        begin
            case (lc)
                "a": note_semi = 4'd9;
                "b": note_semi = 4'd11;
                "c": note_semi = 4'd0;
                "d": note_semi = 4'd2;
                "e": note_semi = 4'd4;
                "f": note_semi = 4'd5;
                default: note_semi = 4'd7;
            endcase
            phase = PH_LETTER;
        end
        else if (lc == "p")
        begin
            note_semi = SEMI_REST;
            phase = PH_LETTER;
        end
        else
            parse_fail();
    endtask

    task automatic close_note();
        int unsigned oct;
        int unsigned ms;
        int unsigned f;
        oct = (accum != 0) ? accum : def_oct;
        ms = 0;
        f = 0;
        if (tempo != 0 && note_dur != 0)
            ms = (240000 / tempo) / note_dur;
        if (dotted)
            ms = ms + ms / 2;
        if (note_semi != SEMI_REST)
        begin
            if (oct < 4 || oct > 7 || note_semi > 11)
            begin
                parse_fail();
                return;
            end
            f = tone_freq(note_semi) << (oct - 4);
        end
        push_result(KIND_NOTE, 12'(f), 16'(ms));
        accum = '0;
        phase = PH_SEP;
    endtask

    // works out the results of one character transaction
    task automatic predict_char(input in_item_t it);
        logic [7:0] c;
        logic       eot;
        logic       dig;
        logic       again;
        c = it.tune_char;
        eot = it.end_of_tune;
        dig = !eot && c >= "0" && c <= "9";
        produced = 0;
        again = !(phase == PH_HALT || halted);
        while (again)
        begin
            again = 1'b0;
            case (phase)
                PH_NAME:
                    if (eot) parse_fail();
                    else if (c == ":")
                    begin
                        def_dur = reg_def_dur;
                        def_oct = reg_def_oct;
                        tempo = reg_tempo;
                        phase = PH_HKEY;
                    end
                PH_HKEY:
                    if (eot) parse_fail();
                    else if (c == ":")
                    begin
                        if (def_dur == 0 || tempo == 0) parse_fail();
                        else
                        begin
                            accum = '0;
                            phase = PH_SEP;
                        end
                    end
                    else if (c == "d") begin hkey = KEY_D; phase = PH_HSKIP; end
                    else if (c == "o") begin hkey = KEY_O; phase = PH_HSKIP; end
                    else if (c == "b") begin hkey = KEY_B; phase = PH_HSKIP; end
                PH_HSKIP:
                    if (eot) parse_fail();
                    else
                    begin
                        accum = '0;
                        phase = PH_HNUM;
                    end
                PH_HNUM:
                    if (dig) accum_digit(c);
                    else
                    begin
                        if (hkey == KEY_D) def_dur = accum[7:0];
                        else if (hkey == KEY_O) def_oct = accum[7:0];
                        else if (hkey == KEY_B) tempo = accum;
                        hkey = KEY_NONE;
                        accum = '0;
                        phase = PH_HKEY;
                        again = 1'b1;
                    end
                PH_SEP:
                    if (eot || c == "," || c == " ") ;
                    else if (dig)
                    begin
                        accum = '0;
                        accum_digit(c);
                        phase = PH_DUR;
                    end
                    else
                    begin
                        note_dur = {8'd0, def_dur};
                        begin_letter(c);
                    end
                PH_DUR:
                    if (dig) accum_digit(c);
                    else
                    begin
                        note_dur = (accum != 0) ? accum : {8'd0, def_dur};
                        accum = '0;
                        if (eot) parse_fail();
                        else begin_letter(c);
                    end
                PH_LETTER:
                begin
                    phase = PH_SHARP;
                    if (!eot && c == "#")
                    begin
                        if (note_semi < 11) note_semi = note_semi + 4'd1;
                    end
                    else
                        again = 1'b1;
                end
                PH_SHARP:
                begin
                    accum = '0;
                    if (!eot && c == ".")
                    begin
                        dotted = 1'b1;
                        phase = PH_OCT;
                    end
                    else if (dig)
                    begin
                        accum_digit(c);
                        phase = PH_OCT;
                    end
                    else
                    begin
                        close_note();
                        again = (phase == PH_SEP);
                    end
                end
                PH_OCT:
                    if (dig) accum_digit(c);
                    else if (!eot && c == ".")
                    begin
                        dotted = 1'b1;
                        close_note();
                    end
                    else
                    begin
                        close_note();
                        again = (phase == PH_SEP);
                    end
                default:
                    phase = PH_HALT;
            endcase
        end
        if (eot)
        begin
            push_result(KIND_END, '0, '0);
            phase = PH_NAME;
            hkey = KEY_NONE;
            accum = '0;
            note_dur = '0;
            note_semi = SEMI_REST;
            dotted = 1'b0;
            halted = 1'b0;
        end
        if (produced > 0)
            expected_notes[$].last = 1'b1;
    endtask

    // ---------------------------------------------------------------- checker
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_notes.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, out_data);
                errors++;
            end
            else
            begin
                want = expected_notes.pop_front();
                if (out_data.result_kind !== want.result_kind
                    || out_data.freq_hz !== want.freq_hz
                    || out_data.dur_ms !== want.dur_ms
                    || out_data.last !== want.last)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
                    errors++;
                end
            end
        end
    end

    // receiver stalls at random
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    // ---------------------------------------------------------------- drivers
    task automatic send_char(input logic [7:0] c, input logic eot);
        in_item_t it;
        it.tune_char = c;
        it.end_of_tune = eot;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_char(it);
        in_valid <= 1'b0;
        // the block is busy right after a transaction, so the next one waits
        @(posedge clk);
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
            send_char(s[i], 1'b0);
    endtask

    task automatic end_tune();
        send_char(8'h00, 1'b1);
    endtask

    // waits for every result, then for the block to go quiet
    task automatic drain();
        while (expected_notes.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DEF_DURATION: reg_def_dur = val[7:0];
            CFG_DEF_OCTAVE:   reg_def_oct = val[7:0];
            default:          reg_tempo = val;
        endcase
        @(posedge clk);
    endtask

    // ---------------------------------------------------------------- tests
    task automatic test_directed();
        // header defaults, sharp, dots, rest, octave range
        send_text("x:d=8,o=5,b=120:c,8d#6.,p,b#.,4a7,g4");
        end_tune();
        // bad letter, then ignored characters until end
        send_text("n::z5c");
        end_tune();
        // zero tempo and early end
        send_text(":b=0:");
        end_tune();
        send_text("ab");
        end_tune();
        send_text("::16");
        end_tune();
        // octave out of range and upper case letters
        send_text("::C3,E.8");
        end_tune();
    endtask

    task automatic test_registers();
        drain();
        write_reg(CFG_DEF_DURATION, 16'd1);
        write_reg(CFG_DEF_OCTAVE, 16'd7);
        write_reg(CFG_TEMPO, 16'd65535);
        send_text("t::a,b#,p,c");
        end_tune();
        drain();
        write_reg(CFG_DEF_DURATION, 16'd255);
        write_reg(CFG_DEF_OCTAVE, 16'd255);
        write_reg(CFG_TEMPO, 16'd1);
        send_text("t::a,p,65535c4.,b=99999");
        end_tune();
        send_text("t:o=0,d=0:");
        end_tune();
        drain();
        write_reg(CFG_DEF_DURATION, 16'd0);
        write_reg(CFG_DEF_OCTAVE, 16'd4);
        write_reg(CFG_TEMPO, 16'd0);
        send_text("t:d=2,b=200:c");
        end_tune();
        drain();
        write_reg(CFG_DEF_DURATION, RST_DEF_DURATION);
        write_reg(CFG_DEF_OCTAVE, RST_DEF_OCTAVE);
        write_reg(CFG_TEMPO, RST_TEMPO);
    endtask

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    // random tunes: mostly well formed, some noise and broken pieces
    task automatic test_random(input int count);
        int sent;
        int k;
        int n;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                n = $urandom_range(12, 1);
                repeat (n) send_char(8'($urandom), 1'($urandom));
                sent += n;
                continue;
            end
            send_text("ab:");
            if ($urandom_range(3) != 0)
            begin
                send_text($sformatf("d=%0d,", $urandom_range(3) == 0 ? $urandom_range(300)
                                                                     : 1 << $urandom_range(5)));
                send_text($sformatf("o=%0d,", $urandom_range(3, 8)));
                send_text($sformatf("b=%0d", $urandom_range(4) == 0 ? $urandom_range(70000)
                                                                   : $urandom_range(400, 1)));
            end
            send_char(":", 1'b0);
            n = $urandom_range(10, 1);
            for (k = 0; k < n; k++)
            begin
                if ($urandom_range(2) == 0) send_text($sformatf("%0d", 1 << $urandom_range(6)));
                if ($urandom_range(30) == 0) send_text("99999");
                send_char($urandom_range(19) == 0 ? pick("hxP!9") : pick("abcdefgpABCG"), 1'b0);
                if ($urandom_range(2) == 0) send_char("#", 1'b0);
                if ($urandom_range(3) == 0) send_char(".", 1'b0);
                if ($urandom_range(1) == 0) send_text($sformatf("%0d", $urandom_range(3, 8)));
                if ($urandom_range(4) == 0) send_char(".", 1'b0);
                send_char(pick(", "), 1'b0);
            end
            sent += n * 5 + 16;
            end_tune();
        end
    endtask

    task automatic test_pause();
        send_text("q::8c,4e5");
        drain();
        end_tune();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_registers();
        send_idle_pct = 29;
        recv_idle_pct = 87;
        test_random(600);
        test_pause();
        send_idle_pct = 87;
        recv_idle_pct = 29;
        test_random(600);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(600);
        drain();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
design/rtpp_pkg.sv
design/rtpp_div.sv
design/rtpp_datapath.sv
design/rtpp_ctrl.sv
design/ringtone_text_note_parser_top.sv
tb/ringtone_text_note_parser_top_test.sv
